@@ sv/lphm_pkg.sv @@
// Package: sizes, operation and status codes, hash helpers for the hash map.
package lphm_pkg;

	localparam int Depth     = 1024;
	localparam int MaxProbes = 8;
	localparam int KeyBytes  = 8;
	localparam int IdxW      = $clog2(Depth);
	localparam int CntW      = $clog2(Depth + 1);
	localparam int PrbW      = $clog2(MaxProbes + 1);
	localparam int ByteW     = $clog2(KeyBytes + 1);
	localparam int KeyW      = 64;
	localparam int ValW      = 32;
	localparam int SlotW     = 1 + KeyW + ValW;
	localparam logic [31:0] CrcPoly  = 32'hEDB88320;
	localparam logic [31:0] KnuthMul = 32'd2654435761;

	typedef enum logic [1:0] {
		FUNC_PUT = 2'd0,
		FUNC_GET = 2'd1,
		FUNC_DEL = 2'd2,
		FUNC_NOP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CRC,
		S_MIX,
		S_MUL,
		S_PROBE,
		S_WAIT,
		S_DONE,
		S_CLEAR
	} state_t;

	// One byte of reflected CRC-32.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

	// One round of the shift-add/xor mix, in 64 bits; four rounds in order.
	function automatic logic [63:0] mix_round(input logic [63:0] h_in, input logic [1:0] step);
		logic [63:0] h;
		h = h_in;
		case (step)
			2'd0: begin
				h = h + (h << 12);
				h = h ^ (h >> 22);
			end
			2'd1: begin
				h = h + (h << 4);
				h = h ^ (h >> 9);
			end
			2'd2: begin
				h = h + (h << 10);
				h = h ^ (h >> 2);
			end
			default: begin
				h = h + (h << 7);
				h = h ^ (h >> 12);
			end
		endcase
		return h;
	endfunction

endpackage

@@ sv/linear_probe_hash_map.sv @@
// Top level: open-addressing hash map with linear probing in one slot memory.
//
// Request channel: func, key and value are taken when start is high and busy
// is low. busy rises in the next cycle and stays high until the result has
// been shown. One request is in work at a time.
// Result channel: status, found, value_out and count are valid for exactly
// one cycle while done is high; the receiver cannot stall it.
// Sequence: the key CRC takes one step per key byte before the first zero
// byte plus a final step, then four mix rounds, a multiply and reduce, then
// 1 to 8 reads of the slot memory (each an address state and a registered
// data state), and a result state with done high. A nop, or a put while
// count is 512 or more, goes from the CRC straight to the result. busy falls
// in the cycle after done, when the next request can be accepted at the earliest.
// Reset: the valid bit of each slot lives in the slot memory; after arst_n a
// clearing pass writes all 1024 slots empty, one per cycle, with busy high,
// so the first request is accepted only once the pass has ended.
// count reports occupied slots after the request.
module linear_probe_hash_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] value_out,
	output logic [9:0]  count
);

	lphm_pkg::state_t state_q, state_d;

	logic [1:0]  func_q;
	logic [63:0] key_q;
	logic [31:0] value_q;
	logic [31:0] crc_q;
	logic [lphm_pkg::ByteW-1:0] byte_q;
	logic [63:0] mix_q;
	logic [1:0]  mix_step_q;
	logic [lphm_pkg::IdxW-1:0] pos_q;
	logic [lphm_pkg::IdxW-1:0] clr_q;
	logic [lphm_pkg::PrbW-1:0] probe_q;
	logic [lphm_pkg::CntW-1:0] cnt_q;
	logic [1:0]  status_q;
	logic        found_q;
	logic [31:0] vout_q;

	logic [lphm_pkg::SlotW-1:0] mem [lphm_pkg::Depth];
	logic [lphm_pkg::SlotW-1:0] rd_s1;

	logic [7:0]  cur_byte;
	logic        crc_end;
	logic [2*lphm_pkg::IdxW-1:0] prod;
	logic        hit;
	logic        empty;
	logic        last_probe;
	logic        is_put;
	logic        room;
	logic        wr_en;
	logic [lphm_pkg::IdxW-1:0]  wr_addr;
	logic [lphm_pkg::SlotW-1:0] wr_data;

	assign cur_byte   = key_q[{byte_q[lphm_pkg::ByteW-2:0], 3'b000} +: 8];
	assign crc_end    = (byte_q == lphm_pkg::ByteW'(lphm_pkg::KeyBytes)) || (cur_byte == 8'd0);
	// only the low index bits of the product survive the reduction
	assign prod       = mix_q[lphm_pkg::IdxW+2:3] * lphm_pkg::KnuthMul[lphm_pkg::IdxW-1:0];
	assign hit        = rd_s1[lphm_pkg::SlotW-1]
	                    && (rd_s1[lphm_pkg::KeyW+lphm_pkg::ValW-1:lphm_pkg::ValW] == key_q);
	assign empty      = !rd_s1[lphm_pkg::SlotW-1];
	assign last_probe = (probe_q == lphm_pkg::PrbW'(lphm_pkg::MaxProbes - 1));
	assign is_put     = (func_q == lphm_pkg::FUNC_PUT);
	assign room       = (cnt_q < lphm_pkg::CntW'(lphm_pkg::Depth / 2));

	always_comb begin
		state_d = state_q;
		case (state_q)
			lphm_pkg::S_CLEAR: begin
				if (clr_q == lphm_pkg::IdxW'(lphm_pkg::Depth - 1))
					state_d = lphm_pkg::S_IDLE;
			end
			lphm_pkg::S_IDLE:  if (start) state_d = lphm_pkg::S_CRC;
			lphm_pkg::S_CRC: begin
				if (crc_end) begin
					if (func_q == lphm_pkg::FUNC_NOP || (is_put && !room))
						state_d = lphm_pkg::S_DONE;
					else
						state_d = lphm_pkg::S_MIX;
				end
			end
			lphm_pkg::S_MIX: begin
				if (mix_step_q == 2'd3)
					state_d = lphm_pkg::S_MUL;
			end
			lphm_pkg::S_MUL:   state_d = lphm_pkg::S_PROBE;
			lphm_pkg::S_PROBE: state_d = lphm_pkg::S_WAIT;
			lphm_pkg::S_WAIT: begin
				if ((is_put && (empty || hit)) || (!is_put && hit) || last_probe)
					state_d = lphm_pkg::S_DONE;
				else
					state_d = lphm_pkg::S_PROBE;
			end
			lphm_pkg::S_DONE:  state_d = lphm_pkg::S_IDLE;
			default:           state_d = lphm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != lphm_pkg::S_IDLE);
		done = (state_q == lphm_pkg::S_DONE);
	end

	// Single write port: clearing pass, put, or delete.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = {1'b1, key_q, value_q};
		if (state_q == lphm_pkg::S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == lphm_pkg::S_WAIT) begin
			if (is_put && (empty || hit)) begin
				wr_en = 1'b1;
			end else if (func_q == lphm_pkg::FUNC_DEL && hit) begin
				wr_en   = 1'b1;
				wr_data = {1'b0, rd_s1[lphm_pkg::SlotW-2:0]};
			end
		end
	end

	assign status    = status_q;
	assign found     = found_q;
	assign value_out = vout_q;
	assign count     = cnt_q[9:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lphm_pkg::S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lphm_pkg::S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (state_q == lphm_pkg::S_WAIT) begin
				if (is_put && (empty || hit)) begin
					if (empty) cnt_q <= cnt_q + 1'b1;
				end else if (func_q == lphm_pkg::FUNC_DEL && hit) begin
					if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Slot memory: one write or one read per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (state_q == lphm_pkg::S_PROBE)
			rd_s1 <= mem[pos_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lphm_pkg::S_IDLE: begin
				func_q   <= func;
				key_q    <= key;
				value_q  <= value;
				crc_q    <= '0;
				byte_q   <= '0;
				probe_q  <= '0;
				status_q <= (func == lphm_pkg::FUNC_PUT) ? lphm_pkg::ST_FULL
				                                          : lphm_pkg::ST_NOTFOUND;
				found_q  <= 1'b0;
				vout_q   <= '0;
			end
			lphm_pkg::S_CRC: begin
				if (!crc_end) begin
					crc_q  <= lphm_pkg::crc_byte(crc_q, cur_byte);
					byte_q <= byte_q + 1'b1;
				end else begin
					mix_q      <= {32'd0, crc_q};
					mix_step_q <= '0;
				end
			end
			lphm_pkg::S_MIX: begin
				mix_q      <= lphm_pkg::mix_round(mix_q, mix_step_q);
				mix_step_q <= mix_step_q + 1'b1;
			end
			lphm_pkg::S_MUL: pos_q <= prod[lphm_pkg::IdxW-1:0];
			lphm_pkg::S_WAIT: begin
				if ((is_put && (empty || hit)) || (!is_put && hit)) begin
					status_q <= lphm_pkg::ST_OK;
					if (func_q == lphm_pkg::FUNC_GET) begin
						found_q <= 1'b1;
						vout_q  <= rd_s1[lphm_pkg::ValW-1:0];
					end
				end else begin
					pos_q   <= pos_q + 1'b1;
					probe_q <= probe_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ dv/tb.sv @@
// Testbench for the linear-probe hash map: directed table, then random put/get/delete/nop traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = lphm_pkg::FUNC_NOP;
	logic [63:0] key = '0;
	logic [31:0] value = '0;
	logic        done;
	logic [1:0]  status;
	logic        found;
	logic [31:0] value_out;
	logic [9:0]  count;

	linear_probe_hash_map u_dut (.*);

	always #5 clk = ~clk;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] value_out;
		logic [9:0]  count;
	} reply_t;

	typedef struct {
		lphm_pkg::func_t op;
		logic [63:0] k;
		logic [31:0] v;
		bit          has_exp;
		reply_t      exp;
	} row_t;

	// predictor copy of the map
	bit          map_valid [lphm_pkg::Depth];
	logic [63:0] map_key   [lphm_pkg::Depth];
	logic [31:0] map_value [lphm_pkg::Depth];
	int unsigned map_entries;

	reply_t      pending_replies[$];
	int          errors = 0;
	int          idle_cycles = 0;
	logic [63:0] key_pool[$];

	function automatic logic [lphm_pkg::IdxW-1:0] slot_of(logic [63:0] k);
		logic [31:0] crc;
		logic [63:0] h;
		logic [7:0]  b;
		crc = '0;
		for (int i = 0; i < lphm_pkg::KeyBytes; i++) begin
			b = k[8*i +: 8];
			if (b == 8'd0) break;
			crc = crc ^ {24'd0, b};
			for (int j = 0; j < 8; j++)
				crc = crc[0] ? ((crc >> 1) ^ 32'hEDB88320) : (crc >> 1);
		end
		h = {32'd0, crc};
		h += h << 12; h ^= h >> 22; h += h << 4;  h ^= h >> 9;
		h += h << 10; h ^= h >> 2;  h += h << 7;  h ^= h >> 12;
		h = (h >> 3) * 64'd2654435761;
		return lphm_pkg::IdxW'(h % lphm_pkg::Depth);
	endfunction

	function automatic reply_t apply_request(lphm_pkg::func_t op, logic [63:0] k,
		logic [31:0] v);
		reply_t r;
		int unsigned p;
		r = '{status: lphm_pkg::ST_NOTFOUND, found: 1'b0, value_out: '0, count: '0};
		if (op == lphm_pkg::FUNC_PUT) begin
			r.status = lphm_pkg::ST_FULL;
			if (map_entries < lphm_pkg::Depth / 2) begin
				p = slot_of(k);
				for (int i = 0; i < lphm_pkg::MaxProbes; i++) begin
					if (!map_valid[p] || map_key[p] == k) begin
						if (!map_valid[p]) begin
							map_valid[p] = 1'b1;
							map_entries++;
						end
						map_key[p] = k;
						map_value[p] = v;
						r.status = lphm_pkg::ST_OK;
						break;
					end
					p = (p + 1) % lphm_pkg::Depth;
				end
			end
		end else if (op == lphm_pkg::FUNC_GET || op == lphm_pkg::FUNC_DEL) begin
			p = slot_of(k);
			for (int i = 0; i < lphm_pkg::MaxProbes; i++) begin
				if (map_valid[p] && map_key[p] == k) begin
					r.status = lphm_pkg::ST_OK;
					if (op == lphm_pkg::FUNC_GET) begin
						r.found = 1'b1;
						r.value_out = map_value[p];
					end else begin
						map_valid[p] = 1'b0;
						if (map_entries > 0) map_entries--;
					end
					break;
				end
				p = (p + 1) % lphm_pkg::Depth;
			end
		end
		r.count = map_entries[9:0];
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n && done) begin
			got = '{status: status, found: found, value_out: value_out, count: count};
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply %p", $time, got);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.found !== want.found)
					$display("%0t: found exp %0d got %0d", $time, want.found, got.found);
				if (got.value_out !== want.value_out)
					$display("%0t: value_out exp %h got %h", $time, want.value_out, got.value_out);
				if (got.count !== want.count)
					$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
				if (got !== want) errors++;
			end
		end
	end

	// watchdog: cycles with no request or reply accepted
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		int n;
		k = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: begin
				n = $urandom_range(0, 7);
				k = (n == 0) ? 64'd0 : (k & ({64{1'b1}} >> (64 - 8 * n)));
			end
			1: k[8*$urandom_range(0, 7) +: 8] = 8'd0;
			default: ;
		endcase
		return k;
	endfunction

	// drive at the falling edge; hold the request until it is taken
	task automatic send(lphm_pkg::func_t op, logic [63:0] k, logic [31:0] v);
		start = 1'b1;
		func  = op;
		key   = k;
		value = v;
		do @(posedge clk); while (busy);
		pending_replies.push_back(apply_request(op, k, v));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic random_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		repeat (g) @(negedge clk);
	endtask

	row_t directed[$];
	row_t rw;
	reply_t got_r;
	logic [63:0] k;
	int pick;

	initial begin
		// expected replies read straight off the spec; the rest use the predictor
		directed = '{
			'{lphm_pkg::FUNC_GET, 64'h41, 32'h0, 1,
				'{lphm_pkg::ST_NOTFOUND, 1'b0, 32'h0, 10'd0}},
			'{lphm_pkg::FUNC_DEL, 64'h41, 32'h0, 1,
				'{lphm_pkg::ST_NOTFOUND, 1'b0, 32'h0, 10'd0}},
			'{lphm_pkg::FUNC_NOP, 64'h41, 32'h5, 1,
				'{lphm_pkg::ST_NOTFOUND, 1'b0, 32'h0, 10'd0}},
			'{lphm_pkg::FUNC_PUT, 64'h41, 32'hFFFF_FFFF, 1,
				'{lphm_pkg::ST_OK, 1'b0, 32'h0, 10'd1}},
			'{lphm_pkg::FUNC_GET, 64'h41, 32'h0, 1,
				'{lphm_pkg::ST_OK, 1'b1, 32'hFFFF_FFFF, 10'd1}},
			'{lphm_pkg::FUNC_PUT, 64'h41, 32'h0, 1,
				'{lphm_pkg::ST_OK, 1'b0, 32'h0, 10'd1}},
			'{lphm_pkg::FUNC_GET, 64'h41, 32'h0, 1,
				'{lphm_pkg::ST_OK, 1'b1, 32'h0, 10'd1}},
			'{lphm_pkg::FUNC_PUT, 64'h0, 32'h1234, 0, '0},
			'{lphm_pkg::FUNC_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 0, '0},
			'{lphm_pkg::FUNC_PUT, 64'hFFFF_FFFF_FFFF_FF00, 32'h1, 0, '0},
			'{lphm_pkg::FUNC_PUT, 64'h1100, 32'h2, 0, '0},
			'{lphm_pkg::FUNC_GET, 64'h0, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_GET, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_GET, 64'h1100, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_DEL, 64'h0, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_GET, 64'h1100, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_DEL, 64'h41, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_DEL, 64'h41, 32'h0, 0, '0},
			'{lphm_pkg::FUNC_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, '0}
		};
		map_entries = 0;
		for (int i = 0; i < lphm_pkg::Depth; i++) map_valid[i] = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			rw = directed[i];
			send(rw.op, rw.k, rw.v);
			if (rw.has_exp) begin
				got_r = pending_replies[pending_replies.size() - 1];
				if (got_r !== rw.exp) begin
					$display("%0t: row %0d exp %p predictor %p", $time, i, rw.exp, got_r);
					errors++;
				end
			end
			random_gap();
		end

		// random traffic; a pool of recently used keys keeps gets and deletes often hitting
		for (int n = 0; n < 2000; n++) begin
			if (n == 1000) begin
				// pause until every reply is back
				while (pending_replies.size() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (key_pool.size() == 0 || pick < 30) begin
				k = random_key();
				key_pool.push_back(k);
				if (key_pool.size() > 700) void'(key_pool.pop_front());
			end else
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			pick = $urandom_range(0, 99);
			if (n < 1200)
				send(pick < 55 ? lphm_pkg::FUNC_PUT : pick < 80 ? lphm_pkg::FUNC_GET
					: pick < 97 ? lphm_pkg::FUNC_DEL : lphm_pkg::FUNC_NOP, k, $urandom);
			else
				send(pick < 25 ? lphm_pkg::FUNC_PUT : pick < 60 ? lphm_pkg::FUNC_GET
					: pick < 97 ? lphm_pkg::FUNC_DEL : lphm_pkg::FUNC_NOP, k, $urandom);
			random_gap();
		end

		while (pending_replies.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/lphm_pkg.sv
sv/linear_probe_hash_map.sv
dv/tb.sv
